FILE: hdl/pli_pkg.sv
`timescale 1ns / 1ps
package pli_pkg;
    localparam int MAX_KNOTS_DEF     = 64;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int VAL_W   = 32;
    localparam int CNT_W   = 7;
    localparam int MODE_W  = 2;
    localparam int STAT_W  = 2;
    localparam int IDX_W   = 6;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    localparam logic [CFG_IDX_W-1:0] REG_KNOT_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_EXTRAP_MODE = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK         = 2'd0;
    localparam logic [STAT_W-1:0] ST_WRITTEN    = 2'd1;
    localparam logic [STAT_W-1:0] ST_ZERO_WIDTH = 2'd2;
    localparam logic [STAT_W-1:0] ST_SATURATED  = 2'd3;

    localparam logic [MODE_W-1:0] MODE_HOLD = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ZERO = 2'd2;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic                     operation;
        logic [IDX_W-1:0]         knot_index;
        logic signed [VAL_W-1:0]  knot_x;
        logic signed [VAL_W-1:0]  knot_y;
        logic signed [VAL_W-1:0]  query_x;
    } t_req;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic [STAT_W-1:0]       status;
    } t_rsp;
endpackage

FILE: hdl/pli_req_if.sv
`timescale 1ns / 1ps
interface pli_req_if import pli_pkg::*; ();
    logic valid;
    logic ready;
    t_req payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

FILE: hdl/pli_rsp_if.sv
`timescale 1ns / 1ps
interface pli_rsp_if import pli_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

FILE: hdl/pli_queue.sv
`timescale 1ns / 1ps
module pli_queue import pli_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_req i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_req o_data
);
    // two-entry queue between front and back
    t_req       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end
endmodule

FILE: hdl/pli_engine.sv
`timescale 1ns / 1ps
module pli_engine import pli_pkg::*; #(
    parameter int MAX_KNOTS = MAX_KNOTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  t_req              i_data,
    output logic              o_pop,
    input  logic [CNT_W-1:0]  i_knot_count,
    input  logic [MODE_W-1:0] i_mode,
    output logic              o_valid,
    output t_rsp              o_data,
    input  logic              i_ready
);
    localparam int AW = $clog2(MAX_KNOTS);

    typedef enum logic [3:0] {
        S_IDLE, S_RD0, S_RDN, S_CHK, S_SCAN, S_SEG, S_SEGB, S_MUL,
        S_DIV, S_FIN, S_OUT
    } t_state;

    logic signed [VAL_W-1:0] r_xmem [MAX_KNOTS];
    logic signed [VAL_W-1:0] r_ymem [MAX_KNOTS];
    logic signed [VAL_W-1:0] r_xrd, r_yrd;
    logic [AW-1:0] r_ra;

    t_state r_st;
    logic signed [VAL_W-1:0] r_q;
    logic [AW-1:0] r_n1, r_k;
    logic signed [VAL_W-1:0] r_x0, r_y0, r_x1, r_y1;
    logic r_below, r_above;
    logic signed [VAL_W:0] r_dx, r_dy, r_t;
    logic [63:0] r_p;
    logic [32:0] r_d;
    logic [64:0] r_rem;
    logic [63:0] r_quo;
    logic [6:0]  r_bit;
    logic r_neg;
    t_rsp r_out;
    logic r_ov;

    logic [CNT_W-1:0] w_nc;
    logic [AW:0] w_n;
    always_comb begin
        w_nc = i_knot_count;
        if (w_nc < CNT_W'(2)) w_nc = CNT_W'(2);
        w_n = (32'(w_nc) > MAX_KNOTS) ? (AW+1)'(MAX_KNOTS) : (AW+1)'(w_nc);
    end

    logic [32:0] w_mdy, w_mt, w_mdx;
    logic [64:0] w_sh;
    logic [64:0] w_dif;
    logic signed [65:0] w_res;
    logic [63:0] w_qr;
    always_comb begin
        w_mdy = r_dy[VAL_W] ? 33'(-r_dy) : 33'(r_dy);
        w_mt  = r_t[VAL_W]  ? 33'(-r_t)  : 33'(r_t);
        w_mdx = r_dx[VAL_W] ? 33'(-r_dx) : 33'(r_dx);
        w_sh  = {r_rem[63:0], r_p[r_bit[5:0]]};
        w_dif = w_sh - 65'(r_d);
        // round half away: remainder >= d - remainder
        w_qr  = (r_rem >= 65'(r_d) - r_rem) ? r_quo + 64'd1 : r_quo;
        w_res = 66'(signed'(r_y0)) + (r_neg ? -$signed({2'b0, w_qr}) : $signed({2'b0, w_qr}));
    end

    assign o_pop   = (r_st == S_IDLE) && i_valid;
    assign o_valid = r_ov;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (o_pop && i_data.operation == OP_WRITE
            && 32'(i_data.knot_index) < MAX_KNOTS) begin
            r_xmem[AW'(i_data.knot_index)] <= i_data.knot_x;
            r_ymem[AW'(i_data.knot_index)] <= i_data.knot_y;
        end
        r_xrd <= r_xmem[r_ra];
        r_yrd <= r_ymem[r_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_ov <= 1'b0;
            r_ra <= '0;
        end else begin
            case (r_st)
                S_IDLE: begin
                    if (i_valid) begin
                        if (i_data.operation == OP_WRITE) begin
                            r_out.value  <= '0;
                            r_out.status <= ST_WRITTEN;
                            r_ov <= 1'b1;
                            r_st <= S_OUT;
                        end else begin
                            r_q  <= i_data.query_x;
                            r_n1 <= AW'(w_n - 1'b1);
                            r_ra <= '0;
                            r_st <= S_RD0;
                        end
                    end
                end
                S_RD0: begin
                    r_ra <= r_n1;
                    r_st <= S_RDN;
                end
                S_RDN: begin
                    r_x0 <= r_xrd;
                    r_y0 <= r_yrd;
                    r_below <= r_q < r_xrd;
                    r_st <= S_CHK;
                end
                S_CHK: begin
                    r_above <= !r_below && r_q > r_xrd;
                    if (r_below || r_q > r_xrd) begin
                        if (i_mode == MODE_HOLD || i_mode == MODE_ZERO) begin
                            r_out.value <= (i_mode == MODE_ZERO) ? '0
                                         : (r_below ? r_y0 : r_yrd);
                            r_out.status <= ST_OK;
                            r_ov <= 1'b1;
                            r_st <= S_OUT;
                        end else begin
                            r_k  <= r_below ? AW'(1) : r_n1;
                            r_ra <= r_below ? AW'(0) : r_n1 - AW'(1);
                            r_st <= S_SEG;
                        end
                    end else begin
                        r_k  <= '0;
                        r_ra <= '0;
                        r_st <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // start the scan at knot zero, one knot per pass through S_SEG and S_SEGB
                    r_st <= S_SEG;
                end
                S_SEG: begin
                    // wait for read data of r_ra
                    r_st <= S_SEGB;
                end
                S_SEGB: begin
                    if (!r_below && !r_above && (r_xrd < r_q) && r_ra != r_n1) begin
                        r_ra <= r_ra + AW'(1);
                        r_st <= S_SEG;
                    end else if (!r_below && !r_above) begin
                        // scan done: knot i = r_ra, segment ends there
                        if (r_ra == '0) begin
                            r_ra <= AW'(1);
                            r_x0 <= r_xrd;
                            r_y0 <= r_yrd;
                            r_below <= 1'b1; // reuse path: fetch end knot
                            r_k <= AW'(1);
                            r_st <= S_SEG;
                        end else begin
                            r_x1 <= r_xrd;
                            r_y1 <= r_yrd;
                            r_ra <= r_ra - AW'(1);
                            r_above <= 1'b1;
                            r_k <= r_ra;
                            r_st <= S_SEG;
                        end
                    end else if (r_ra != r_k) begin
                        r_x0 <= r_xrd;
                        r_y0 <= r_yrd;
                        r_ra <= r_k;
                        r_st <= S_SEG;
                    end else begin
                        // end knot of the segment
                        r_x1 <= r_xrd;
                        r_y1 <= r_yrd;
                        r_st <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_dx <= (VAL_W+1)'(r_x1) - (VAL_W+1)'(r_x0);
                    r_dy <= (VAL_W+1)'(r_y1) - (VAL_W+1)'(r_y0);
                    r_t  <= (VAL_W+1)'(r_q) - (VAL_W+1)'(r_x0);
                    r_st <= S_DIV;
                    r_bit <= 7'd64;
                end
                S_DIV: begin
                    if (r_bit == 7'd64) begin
                        if (r_dx == '0) begin
                            r_out.value <= '0;
                            r_out.status <= ST_ZERO_WIDTH;
                            r_ov <= 1'b1;
                            r_st <= S_OUT;
                        end else begin
                            r_p <= 64'(w_mdy) * 64'(w_mt);
                            r_d <= w_mdx;
                            r_neg <= (r_dy[VAL_W] != r_t[VAL_W]) != r_dx[VAL_W];
                            r_rem <= '0;
                            r_quo <= '0;
                            r_bit <= 7'd63;
                        end
                    end else begin
                        if (w_sh >= 65'(r_d)) begin
                            r_rem <= w_dif;
                            r_quo <= {r_quo[62:0], 1'b1};
                        end else begin
                            r_rem <= w_sh;
                            r_quo <= {r_quo[62:0], 1'b0};
                        end
                        if (r_bit == 7'd0) r_st <= S_FIN;
                        else r_bit <= r_bit - 7'd1;
                    end
                end
                S_FIN: begin
                    r_ov <= 1'b1;
                    r_st <= S_OUT;
                    if (w_qr > (64'd1 << 40)) begin
                        r_out.status <= ST_SATURATED;
                        r_out.value <= r_neg ? 32'sh80000000 : 32'sh7fffffff;
                    end else if (w_res > 66'sh7fffffff) begin
                        r_out.status <= ST_SATURATED;
                        r_out.value <= 32'sh7fffffff;
                    end else if (w_res < -66'sh80000000) begin
                        r_out.status <= ST_SATURATED;
                        r_out.value <= 32'sh80000000;
                    end else begin
                        r_out.status <= ST_OK;
                        r_out.value <= VAL_W'(w_res);
                    end
                end
                S_OUT: begin
                    if (i_ready) begin
                        r_ov <= 1'b0;
                        r_st <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule

FILE: hdl/piecewise_linear_interpolator_core.sv
`timescale 1ns / 1ps
// Piecewise linear interpolator. Requests on req either write one knot
// (x, y) into the table or query a point; each request gives exactly one
// response. A query reads the two end knots and, for x inside the table,
// scans it one knot per pass through S_SEG and S_SEGB (registered memory
// read) for the first knot at or above x, fetches the segment and runs a
// 64-step restoring divider with rounding. A two-entry request queue
// decouples the handshake from the engine. Configuration must be written
// only when idle, by the user; the block itself does not enforce it.
module piecewise_linear_interpolator_core import pli_pkg::*; #(
    parameter int MAX_KNOTS = MAX_KNOTS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    pli_req_if.sink               req,
    pli_rsp_if.source             rsp,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);
    logic [CNT_W-1:0]  r_knot_count;
    logic [MODE_W-1:0] r_mode;
    logic w_full, w_qv, w_pop;
    t_req w_qd;

    // register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_knot_count <= CNT_W'(2);
            r_mode <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_KNOT_COUNT:  r_knot_count <= i_cfg_data;
                REG_EXTRAP_MODE: r_mode <= i_cfg_data[MODE_W-1:0];
                default: ;
            endcase
        end
    end

    assign req.ready = !w_full;

    pli_queue u_queue (
        .i_clk, .i_rst_n,
        .i_push (req.valid && !w_full),
        .i_data (req.payload),
        .o_full (w_full),
        .i_pop  (w_pop),
        .o_valid(w_qv),
        .o_data (w_qd)
    );

    pli_engine #(.MAX_KNOTS(MAX_KNOTS)) u_engine (
        .i_clk, .i_rst_n,
        .i_valid     (w_qv),
        .i_data      (w_qd),
        .o_pop       (w_pop),
        .i_knot_count(r_knot_count),
        .i_mode      (r_mode),
        .o_valid     (rsp.valid),
        .o_data      (rsp.payload),
        .i_ready     (rsp.ready)
    );
endmodule

FILE: test/piecewise_linear_interpolator_core_tb.sv
`timescale 1ns / 1ps
module piecewise_linear_interpolator_core_tb;
    import pli_pkg::*;

    // One pending request together with an optional hand-typed response.
    typedef struct {
        t_req req;
        bit   typed;
        t_rsp rsp;
    } t_item;

    // Row of the directed table.
    typedef struct {
        logic        op;
        logic [5:0]  idx;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] q;
        bit          typed;
        logic [31:0] val;
        logic [1:0]  st;
    } t_row;

    localparam int N_PHASES = 12;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    pli_req_if req ();
    pli_rsp_if rsp ();

    piecewise_linear_interpolator_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .req        (req.sink),
        .rsp        (rsp.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Shadow of the block: knot table and configuration as the block sees them.
    logic signed [31:0] knot_x_tbl [MAX_KNOTS_DEF];
    logic signed [31:0] knot_y_tbl [MAX_KNOTS_DEF];
    logic [CNT_W-1:0]   cur_count;
    logic [MODE_W-1:0]  cur_mode;

    // What the stimulus side knows it has written, so queries never read
    // a table entry that holds nothing yet.
    bit                 gen_written [MAX_KNOTS_DEF];
    logic signed [31:0] gen_x [MAX_KNOTS_DEF];

    t_item backlog [$];
    t_rsp  pending_rsp [$];
    bit    req_fired;
    int    send_idle_pct;
    int    recv_idle_pct;
    bit    pressure_req;
    int    mismatches;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("tb: failure");
        $finish;
    end

    function automatic int used_knots(logic [CNT_W-1:0] c);
        if (c < 2) return 2;
        if (c > MAX_KNOTS_DEF) return MAX_KNOTS_DEF;
        return int'(c);
    endfunction

    // Interpolate on segment (a, b); rounds the quotient to nearest, ties
    // away from zero, and saturates the sum.
    function automatic logic signed [31:0] segment_value(int a, int b, longint q,
                                                         output logic [1:0] st);
        longint      x1, dx, y1, dy, t, res;
        logic [63:0] p, d, quo, rem, mdy, mt;
        bit          neg;
        x1 = knot_x_tbl[a];
        dx = longint'(knot_x_tbl[b]) - x1;
        y1 = knot_y_tbl[a];
        dy = longint'(knot_y_tbl[b]) - y1;
        t  = q - x1;
        if (dx == 0) begin
            st = ST_ZERO_WIDTH;
            return '0;
        end
        mdy = (dy < 0) ? -dy : dy;
        mt  = (t < 0) ? -t : t;
        d   = (dx < 0) ? -dx : dx;
        p   = mdy * mt;
        quo = p / d;
        rem = p % d;
        if (rem >= d - rem) quo++;
        neg = ((dy < 0) != (t < 0)) != (dx < 0);
        st = ST_OK;
        if (quo > (64'd1 << 40)) begin
            st = ST_SATURATED;
            return neg ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end
        res = neg ? y1 - longint'(quo) : y1 + longint'(quo);
        if (res > 64'sd2147483647) begin
            st = ST_SATURATED;
            return 32'sh7fff_ffff;
        end
        if (res < -64'sd2147483648) begin
            st = ST_SATURATED;
            return 32'sh8000_0000;
        end
        return res[31:0];
    endfunction

    // Apply one accepted request to the shadow and return its response.
    function automatic t_rsp interpolate(t_req r);
        t_rsp   o;
        int     n, i;
        longint q;
        bit     below, above;
        o.value  = '0;
        o.status = ST_OK;
        if (r.operation == OP_WRITE) begin
            knot_x_tbl[r.knot_index] = r.knot_x;
            knot_y_tbl[r.knot_index] = r.knot_y;
            o.status = ST_WRITTEN;
            return o;
        end
        n = used_knots(cur_count);
        q = r.query_x;
        below = q < knot_x_tbl[0];
        above = !below && q > knot_x_tbl[n-1];
        if (below || above) begin
            if (cur_mode == MODE_HOLD)
                o.value = below ? knot_y_tbl[0] : knot_y_tbl[n-1];
            else if (cur_mode == MODE_ZERO)
                o.value = '0;
            else if (below)
                o.value = segment_value(0, 1, q, o.status);
            else
                o.value = segment_value(n-2, n-1, q, o.status);
        end else begin
            i = n - 1;
            for (int k = 0; k < n; k++) begin
                if (knot_x_tbl[k] >= q) begin
                    i = k;
                    break;
                end
            end
            if (i == 0) i = 1;
            o.value = segment_value(i-1, i, q, o.status);
        end
        return o;
    endfunction

    // Sample both handshakes at the rising edge; predict on every accepted
    // request, check every accepted response against the oldest expectation.
    always @(posedge i_clk) begin
        t_rsp want, got;
        if (req.valid && req.ready && backlog.size() > 0) begin
            want = interpolate(backlog[0].req);
            if (backlog[0].typed) want = backlog[0].rsp;
            pending_rsp.push_back(want);
            void'(backlog.pop_front());
            req_fired = 1'b1;
        end
        if (rsp.valid && rsp.ready) begin
            got = rsp.payload;
            if (pending_rsp.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected response value=%h status=%0d",
                             got.value, got.status);
            end else begin
                want = pending_rsp.pop_front();
                if (got.value !== want.value || got.status !== want.status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected value=%h status=%0d, got value=%h status=%0d",
                                 want.value, want.status, got.value, got.status);
                end
            end
        end
    end

    // Request driver: hold a request until it is taken, then advance,
    // idling at random between requests.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req.valid = 1'b0;
        end else if (req.valid && !req_fired) begin
            req.valid = 1'b1;
        end else if (backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req.valid   = 1'b1;
            req.payload = backlog[0].req;
        end else begin
            req.valid = 1'b0;
        end
        req_fired = 1'b0;
    end

    // Response side: random stalls, plus one long hold-off that lets the
    // block fill up and back-pressure its input.
    initial begin
        int hold;
        hold = 0;
        rsp.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (pressure_req) begin
                pressure_req = 1'b0;
                hold = 1500;
            end
            if (hold > 0) begin
                hold--;
                rsp.ready = 1'b0;
            end else begin
                rsp.ready = ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic push_item(t_req r, bit typed, t_rsp o);
        t_item it;
        it.req = r;
        it.typed = typed;
        it.rsp = o;
        backlog.push_back(it);
        if (r.operation == OP_WRITE) begin
            gen_written[r.knot_index] = 1'b1;
            gen_x[r.knot_index] = r.knot_x;
        end
    endtask

    task automatic push_write(int idx, logic [31:0] x, logic [31:0] y);
        t_req r;
        t_rsp o;
        r = '0;
        r.operation = OP_WRITE;
        r.knot_index = IDX_W'(idx);
        r.knot_x = x;
        r.knot_y = y;
        o = '0;
        push_item(r, 1'b0, o);
    endtask

    task automatic wait_idle;
        while (backlog.size() > 0 || req.valid || pending_rsp.size() > 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        if (idx == REG_KNOT_COUNT) cur_count = data;
        else cur_mode = data[MODE_W-1:0];
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // Pick a query point: mostly inside or just around the table, sometimes
    // exactly on a knot, sometimes anywhere, sometimes at an extreme.
    function automatic logic [31:0] pick_query(int n);
        int k, sel;
        sel = $urandom_range(99);
        k = $urandom_range(n - 1);
        if (sel < 50)
            return gen_x[k] + $urandom_range(32'h40000) - 32'h20000;
        if (sel < 70)
            return gen_x[k];
        if (sel < 90)
            return $urandom;
        return ($urandom_range(1) != 0) ? 32'h7fff_ffff : 32'h8000_0000;
    endfunction

    function automatic logic [31:0] pick_ordinate();
        if ($urandom_range(9) == 0) return $urandom;
        return $urandom_range(32'h20_0000) - 32'h10_0000;
    endfunction

    t_row directed [18] = '{
        '{OP_WRITE, 6'd0,  32'h0,         32'h0,         32'h0,         1'b1, 32'h0, ST_WRITTEN},
        '{OP_WRITE, 6'd1,  32'h0001_0000, 32'h0002_0000, 32'h0,         1'b1, 32'h0, ST_WRITTEN},
        '{OP_QUERY, 6'd0,  32'h0,         32'h0,         32'h0000_8000, 1'b1, 32'h0001_0000, ST_OK},
        '{OP_QUERY, 6'd0,  32'h0,         32'h0,         32'h0,         1'b1, 32'h0, ST_OK},
        '{OP_QUERY, 6'd0,  32'h0,         32'h0,         32'h0001_0000, 1'b1, 32'h0002_0000, ST_OK},
        '{OP_QUERY, 6'd0,  32'h0,         32'h0,         32'hffff_0000, 1'b1, 32'hfffe_0000, ST_OK},
        '{OP_QUERY, 6'd0,  32'h0,         32'h0,         32'h7fff_ffff, 1'b1, 32'h7fff_ffff, ST_SATURATED},
        '{OP_QUERY, 6'd0,  32'h0,         32'h0,         32'h8000_0000, 1'b1, 32'h8000_0000, ST_SATURATED},
        '{OP_WRITE, 6'd63, 32'h7fff_ffff, 32'h8000_0000, 32'h0,         1'b1, 32'h0, ST_WRITTEN},
        '{OP_WRITE, 6'd1,  32'h0,         32'h5,         32'h0,         1'b1, 32'h0, ST_WRITTEN},
        '{OP_QUERY, 6'd0,  32'h0,         32'h0,         32'h0,         1'b1, 32'h0, ST_ZERO_WIDTH},
        '{OP_QUERY, 6'd0,  32'h0,         32'h0,         32'h8000_0000, 1'b1, 32'h0, ST_ZERO_WIDTH},
        '{OP_WRITE, 6'd1,  32'h1,         32'hc000_0000, 32'h0,         1'b1, 32'h0, ST_WRITTEN},
        '{OP_QUERY, 6'd0,  32'h0,         32'h0,         32'h3,         1'b1, 32'h8000_0000, ST_SATURATED},
        '{OP_QUERY, 6'd0,  32'h0,         32'h0,         32'h1,         1'b1, 32'hc000_0000, ST_OK},
        '{OP_WRITE, 6'd1,  32'h0001_0000, 32'h7fff_ffff, 32'h0,         1'b1, 32'h0, ST_WRITTEN},
        // tie in the rounding: half of 0x7fffffff rounds away from zero
        '{OP_QUERY, 6'd0,  32'h0,         32'h0,         32'h0000_8000, 1'b1, 32'h4000_0000, ST_OK},
        '{OP_QUERY, 6'd0,  32'h0,         32'h0,         32'h0000_4000, 1'b0, 32'h0, ST_OK}
    };

    // Knot counts and modes of the phases; the extremes and the
    // out-of-range counts (which clamp to 2 and to the table size) included.
    int phase_count [N_PHASES] = '{2, 64, 5, 0, 127, 8, 3, 1, 16, 100, 4, 2};
    int phase_mode  [N_PHASES] = '{0, 1, 2, 3, 0, 1, 2, 3, 3, 2, 1, 0};

    initial begin
        t_req r;
        t_rsp o;
        int n, per_phase;
        logic signed [31:0] x;

        req.valid = 1'b0;
        req.payload = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        i_rst_n = 1'b0;
        req_fired = 1'b0;
        pressure_req = 1'b0;
        mismatches = 0;
        send_idle_pct = 7;
        recv_idle_pct = 70;
        cur_count = CNT_W'(2);
        cur_mode = '0;
        foreach (knot_x_tbl[k]) begin
            knot_x_tbl[k] = '0;
            knot_y_tbl[k] = '0;
            gen_written[k] = 1'b0;
            gen_x[k] = '0;
        end
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part, under the reset configuration.
        foreach (directed[k]) begin
            r = '0;
            r.operation = directed[k].op;
            r.knot_index = directed[k].idx;
            r.knot_x = directed[k].x;
            r.knot_y = directed[k].y;
            r.query_x = directed[k].q;
            o.value = directed[k].val;
            o.status = directed[k].st;
            push_item(r, directed[k].typed, o);
        end
        wait_idle();

        per_phase = 100;
        for (int p = 0; p < N_PHASES; p++) begin
            // Change the idle pattern by thirds of the run.
            if (p < N_PHASES / 3) begin
                send_idle_pct = 7;
                recv_idle_pct = 70;
            end else if (p < 2 * N_PHASES / 3) begin
                send_idle_pct = 70;
                recv_idle_pct = 7;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            wait_idle();
            write_reg(REG_KNOT_COUNT, CFG_DATA_W'(phase_count[p]));
            write_reg(REG_EXTRAP_MODE, CFG_DATA_W'(phase_mode[p]));
            n = used_knots(cur_count);
            if (p == 2) pressure_req = 1'b1;

            // Load a rising table; a zero step now and then gives a
            // zero-width segment.
            x = $urandom_range(32'h4000_0000) - 32'h2000_0000;
            for (int k = 0; k < n; k++) begin
                push_write(k, x, pick_ordinate());
                x = x + (($urandom_range(19) == 0) ? 0 : $urandom_range(32'h4_0000, 1));
            end

            for (int j = 0; j < per_phase - n / 2; j++) begin
                r = '0;
                if ($urandom_range(9) < 8) begin
                    r.operation = OP_QUERY;
                    r.query_x = pick_query(n);
                    r.knot_x = $urandom;
                    r.knot_y = $urandom;
                    r.knot_index = IDX_W'($urandom);
                    o = '0;
                    push_item(r, 1'b0, o);
                end else if ($urandom_range(1) != 0) begin
                    // Disturb a used knot: may unsort the table.
                    push_write($urandom_range(n - 1),
                               ($urandom_range(3) == 0) ? $urandom
                                   : gen_x[$urandom_range(n - 1)] + $urandom_range(255),
                               pick_ordinate());
                end else begin
                    push_write($urandom_range(MAX_KNOTS_DEF - 1), $urandom, $urandom);
                end
                // Keep the backlog short so idling shapes the traffic.
                while (backlog.size() > 4) @(posedge i_clk);
            end
        end

        wait_idle();
        repeat (400) @(posedge i_clk);
        if (mismatches == 0 && pending_rsp.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
